// ----- hw/rtl/dpa_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dpa_pkg: shared types and constants of the dense polynomial ALU
// Coefficient store geometry, opcodes, register indexes and beat formats.
// ----------------------------------------------------------------------------
package dpa_pkg;

    localparam int MAX_TERMS  = 8;
    localparam int COEF_WIDTH = 16;
    localparam int IDX_W      = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam int DEG_W      = 3;
    localparam int OPC_W      = 3;
    localparam int TIDX_W     = 3;
    localparam int CIN_W      = 16;
    localparam int RES_W      = 32;
    localparam int EXP_W      = 4;
    localparam int REG_IDX_W  = 1;

    localparam logic [REG_IDX_W-1:0] REG_DEGREE_A = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_DEGREE_B = 1'b1;

    typedef enum logic [OPC_W-1:0] {
        OP_LOAD_A = 3'd0,
        OP_LOAD_B = 3'd1,
        OP_ADD    = 3'd2,
        OP_SUB    = 3'd3,
        OP_MUL    = 3'd4
    } opcode_t;

    typedef struct packed {
        logic [OPC_W-1:0]         opcode;
        logic [TIDX_W-1:0]        term_index;
        logic signed [CIN_W-1:0]  coefficient_in;
    } in_item_t;

    typedef struct packed {
        logic signed [RES_W-1:0]  coefficient_out;
        logic [EXP_W-1:0]         exponent_out;
        logic                     last_term;
    } out_item_t;

    typedef struct packed {
        logic             valid;
        opcode_t          op;
        logic             a_en;
        logic             b_en;
        logic [EXP_W-1:0] exponent;
        logic             last;
    } term_ctrl_t;

endpackage : dpa_pkg
`default_nettype wire

// ----- hw/rtl/dpa_coef_store.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dpa_coef_store: coefficient stores of polynomials A and B
// One write port shared by both stores, one read port per store.
// ----------------------------------------------------------------------------
module dpa_coef_store
    import dpa_pkg::*;
(
    input  wire logic                         aclk,
    input  wire logic                         wr_en,
    input  wire logic                         wr_sel_b,
    input  wire logic [IDX_W-1:0]             wr_addr,
    input  wire logic signed [COEF_WIDTH-1:0] wr_data,
    input  wire logic [IDX_W-1:0]             rd_addr_a,
    input  wire logic [IDX_W-1:0]             rd_addr_b,
    output logic signed [COEF_WIDTH-1:0]      rd_data_a,
    output logic signed [COEF_WIDTH-1:0]      rd_data_b
);

    logic signed [COEF_WIDTH-1:0] store_a_reg [MAX_TERMS];
    logic signed [COEF_WIDTH-1:0] store_b_reg [MAX_TERMS];

    always_ff @(posedge aclk) begin
        if (wr_en && !wr_sel_b) begin
            store_a_reg[wr_addr] <= wr_data;
        end
        if (wr_en && wr_sel_b) begin
            store_b_reg[wr_addr] <= wr_data;
        end
    end

    assign rd_data_a = store_a_reg[rd_addr_a];
    assign rd_data_b = store_b_reg[rd_addr_b];

endmodule : dpa_coef_store
`default_nettype wire

// ----- hw/rtl/dpa_sequencer.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dpa_sequencer: term sequencer of the dense polynomial ALU
// Steps the exponent counters of a command and issues one term per slot.
// ----------------------------------------------------------------------------
module dpa_sequencer
    import dpa_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire opcode_t          start_op,
    input  wire logic [DEG_W-1:0] degree_a,
    input  wire logic [DEG_W-1:0] degree_b,
    input  wire logic             advance,
    output logic                  busy,
    output logic [IDX_W-1:0]      outer_idx,
    output logic [IDX_W-1:0]      inner_idx,
    output term_ctrl_t            ctrl
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

    state_t           state_reg, state_next;
    opcode_t          op_reg, op_next;
    logic [IDX_W-1:0] outer_reg, outer_next;
    logic [IDX_W-1:0] inner_reg, inner_next;
    logic [IDX_W-1:0] da, db, top;
    logic             last;

    always_comb begin
        if (DEG_W'(MAX_TERMS - 1) < degree_a) begin
            da = IDX_W'(MAX_TERMS - 1);
        end else begin
            da = degree_a[IDX_W-1:0];
        end
        if (DEG_W'(MAX_TERMS - 1) < degree_b) begin
            db = IDX_W'(MAX_TERMS - 1);
        end else begin
            db = degree_b[IDX_W-1:0];
        end
        top = (da > db) ? da : db;
    end

    always_comb begin
        ctrl.valid    = 1'b0;
        ctrl.op       = op_reg;
        ctrl.a_en     = 1'b1;
        ctrl.b_en     = 1'b1;
        ctrl.exponent = EXP_W'(outer_reg);
        last          = 1'b0;
        state_next    = state_reg;
        op_next       = op_reg;
        outer_next    = outer_reg;
        inner_next    = inner_reg;

        if (op_reg == OP_MUL) begin
            ctrl.exponent = EXP_W'(outer_reg) + EXP_W'(inner_reg);
            last          = (outer_reg == da) && (inner_reg == db);
        end else begin
            ctrl.a_en = (outer_reg <= da);
            ctrl.b_en = (outer_reg <= db);
            last      = (outer_reg == top);
        end
        ctrl.last = last;

        unique case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    state_next = ST_RUN;
                    op_next    = start_op;
                    outer_next = '0;
                    inner_next = '0;
                end
            end
            ST_RUN: begin
                if (advance) begin
                    ctrl.valid = 1'b1;
                    if (last) begin
                        state_next = ST_IDLE;
                        outer_next = '0;
                        inner_next = '0;
                    end else if (op_reg == OP_MUL) begin
                        if (inner_reg == db) begin
                            inner_next = '0;
                            outer_next = outer_reg + 1'b1;
                        end else begin
                            inner_next = inner_reg + 1'b1;
                        end
                    end else begin
                        outer_next = outer_reg + 1'b1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            op_reg    <= OP_ADD;
            outer_reg <= '0;
            inner_reg <= '0;
        end else begin
            state_reg <= state_next;
            op_reg    <= op_next;
            outer_reg <= outer_next;
            inner_reg <= inner_next;
        end
    end

    assign busy      = (state_reg != ST_IDLE);
    assign outer_idx = outer_reg;
    assign inner_idx = (op_reg == OP_MUL) ? inner_reg : outer_reg;

endmodule : dpa_sequencer
`default_nettype wire

// ----- hw/rtl/dpa_arith_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dpa_arith_unit: shared add, subtract and multiply unit
// Forms one result term per issued slot and holds it in the output register.
// ----------------------------------------------------------------------------
module dpa_arith_unit
    import dpa_pkg::*;
(
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire term_ctrl_t                   ctrl,
    input  wire logic signed [COEF_WIDTH-1:0] coef_a,
    input  wire logic signed [COEF_WIDTH-1:0] coef_b,
    output logic                              advance,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output out_item_t                         m_data
);

    logic signed [RES_W-1:0] op_a, op_b, result;
    logic                    m_valid_reg, m_valid_next;
    out_item_t               m_data_reg;

    always_comb begin
        op_a = ctrl.a_en ? RES_W'(coef_a) : '0;
        op_b = ctrl.b_en ? RES_W'(coef_b) : '0;
        unique case (ctrl.op)
            OP_ADD:  result = op_a + op_b;
            OP_SUB:  result = op_a - op_b;
            OP_MUL:  result = op_a * op_b;
            default: result = '0;
        endcase
    end

    assign advance = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (ctrl.valid) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.valid) begin
            m_data_reg.coefficient_out <= result;
            m_data_reg.exponent_out    <= ctrl.exponent;
            m_data_reg.last_term       <= ctrl.last;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule : dpa_arith_unit
`default_nettype wire

// ----- hw/rtl/dense_polynomial_alu.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dense_polynomial_alu: add, subtract and multiply of two dense polynomials
// Load beats fill the A and B coefficient stores; command beats stream terms.
// ----------------------------------------------------------------------------
// Loads stream at one per cycle while no command is running. A
// command beat makes s_ready fall until its last term has been handed to the
// output register: add and subtract produce max(degree_a, degree_b) + 1 terms,
// multiply produces (degree_a + 1) * (degree_b + 1) terms, one per cycle from
// the single shared arithmetic unit while m_ready is high, so output stalls
// also hold the input off. The user must write degrees through the cfg port
// only while the block is idle; the block does not enforce this. A store
// entry must be loaded before a command reads it.
module dense_polynomial_alu
    import dpa_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_we,
    input  wire logic [REG_IDX_W-1:0] cfg_index,
    input  wire logic [DEG_W-1:0]     cfg_wdata,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire in_item_t             s_data,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output out_item_t                 m_data
);

    logic [DEG_W-1:0]             degree_a_reg, degree_b_reg;
    logic                         busy, advance, accept, is_load, is_cmd, wr_en;
    logic [IDX_W-1:0]             outer_idx, inner_idx;
    logic signed [COEF_WIDTH-1:0] coef_a, coef_b, wr_data;
    term_ctrl_t                   ctrl;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            degree_a_reg <= '0;
            degree_b_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_DEGREE_A: degree_a_reg <= cfg_wdata;
                REG_DEGREE_B: degree_b_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign s_ready = !busy;
    assign accept  = s_valid && s_ready;
    assign is_load = (s_data.opcode == OP_LOAD_A) || (s_data.opcode == OP_LOAD_B);
    assign is_cmd  = (s_data.opcode == OP_ADD) || (s_data.opcode == OP_SUB)
                  || (s_data.opcode == OP_MUL);
    assign wr_en   = accept && is_load
                  && ({1'b0, s_data.term_index} < (TIDX_W + 1)'(MAX_TERMS));
    assign wr_data = COEF_WIDTH'(s_data.coefficient_in);

    dpa_coef_store u_store (
        .aclk      (aclk),
        .wr_en     (wr_en),
        .wr_sel_b  (s_data.opcode == OP_LOAD_B),
        .wr_addr   (s_data.term_index[IDX_W-1:0]),
        .wr_data   (wr_data),
        .rd_addr_a (outer_idx),
        .rd_addr_b (inner_idx),
        .rd_data_a (coef_a),
        .rd_data_b (coef_b)
    );

    dpa_sequencer u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (accept && is_cmd),
        .start_op  (opcode_t'(s_data.opcode)),
        .degree_a  (degree_a_reg),
        .degree_b  (degree_b_reg),
        .advance   (advance),
        .busy      (busy),
        .outer_idx (outer_idx),
        .inner_idx (inner_idx),
        .ctrl      (ctrl)
    );

    dpa_arith_unit u_arith (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ctrl),
        .coef_a  (coef_a),
        .coef_b  (coef_b),
        .advance (advance),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule : dense_polynomial_alu
`default_nettype wire

// ----- tb/sv/dense_polynomial_alu_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dense_polynomial_alu_tb: self-checking bench for the dense polynomial ALU
// Both stores are filled first. Random load and command beats then run under
// several degree settings. The sender works in bursts and the receiver stalls
// on its own pattern. Every result beat is checked against a predicted term
// list.
// ----------------------------------------------------------------------------
module dense_polynomial_alu_tb;
    import dpa_pkg::*;

    localparam logic [DEG_W-1:0] DEG_TOP = DEG_W'(MAX_TERMS - 1);

    typedef enum int {RX_FREE, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [REG_IDX_W-1:0] cfg_index = '0;
    logic [DEG_W-1:0]     cfg_wdata = '0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    in_item_t             s_data    = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    out_item_t            m_data;

    in_item_t  pending_beats[$];
    out_item_t expected_terms[$];
    out_item_t want;

    logic signed [CIN_W-1:0] poly_a [MAX_TERMS];
    logic signed [CIN_W-1:0] poly_b [MAX_TERMS];
    logic [DEG_W-1:0]        deg_a = '0;
    logic [DEG_W-1:0]        deg_b = '0;

    int       mismatch_count = 0;
    int       burst_left     = 0;
    int       gap_left       = 0;
    int       rx_left        = 0;
    rx_mode_t rx_mode        = RX_FREE;
    logic [7:0] rx_tick      = '0;

    dense_polynomial_alu dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic logic signed [CIN_W-1:0] edge_coef(int k);
        case (k)
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return 16'sh0000;
            3: return 16'shFFFF;
            4: return 16'sh0001;
            5: return 16'sh5555;
            6: return 16'shAAAA;
            default: return 16'sh0100;
        endcase
    endfunction

    function automatic in_item_t make_beat(logic [OPC_W-1:0] op, int idx,
                                           logic signed [CIN_W-1:0] coef);
        in_item_t beat;
        beat.opcode         = op;
        beat.term_index     = TIDX_W'(idx);
        beat.coefficient_in = coef;
        return beat;
    endfunction

    function automatic in_item_t random_beat();
        int              pick;
        logic [OPC_W-1:0] op;
        logic signed [CIN_W-1:0] coef;
        pick = $urandom_range(0, 99);
        if (pick < 30)      op = OP_LOAD_A;
        else if (pick < 60) op = OP_LOAD_B;
        else if (pick < 70) op = OP_ADD;
        else if (pick < 80) op = OP_SUB;
        else if (pick < 95) op = OP_MUL;
        else                op = OPC_W'($urandom_range(int'(OP_MUL) + 1, (1 << OPC_W) - 1));
        if ($urandom_range(0, 3) == 0) coef = edge_coef($urandom_range(0, 7));
        else                           coef = CIN_W'($urandom);
        return make_beat(op, $urandom_range(0, MAX_TERMS - 1), coef);
    endfunction

    // Works out the result terms of one accepted beat and updates the stores.
    function automatic void predict_terms(in_item_t beat);
        out_item_t               term;
        logic signed [RES_W-1:0] lhs;
        logic signed [RES_W-1:0] rhs;
        logic [DEG_W-1:0]        top;
        case (beat.opcode)
            OP_LOAD_A: poly_a[beat.term_index] = beat.coefficient_in;
            OP_LOAD_B: poly_b[beat.term_index] = beat.coefficient_in;
            OP_ADD, OP_SUB: begin
                top = (deg_a > deg_b) ? deg_a : deg_b;
                for (int e = 0; e <= int'(top); e++) begin
                    lhs = '0;
                    rhs = '0;
                    if (e <= int'(deg_a)) lhs = poly_a[e];
                    if (e <= int'(deg_b)) rhs = poly_b[e];
                    term.coefficient_out = (beat.opcode == OP_ADD) ? lhs + rhs : lhs - rhs;
                    term.exponent_out    = EXP_W'(e);
                    term.last_term       = (e == int'(top));
                    expected_terms.push_back(term);
                end
            end
            OP_MUL: begin
                for (int i = 0; i <= int'(deg_a); i++) begin
                    for (int j = 0; j <= int'(deg_b); j++) begin
                        lhs = poly_a[i];
                        rhs = poly_b[j];
                        term.coefficient_out = lhs * rhs;
                        term.exponent_out    = EXP_W'(i + j);
                        term.last_term       = (i == int'(deg_a)) && (j == int'(deg_b));
                        expected_terms.push_back(term);
                    end
                end
            end
            default: ;
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatch_count < 50) $display("ERROR at %0t ns: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic set_degrees(input logic [DEG_W-1:0] da, input logic [DEG_W-1:0] db);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_DEGREE_A;
        cfg_wdata <= da;
        deg_a = da;
        @(posedge aclk);
        cfg_index <= REG_DEGREE_B;
        cfg_wdata <= db;
        deg_b = db;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_idle();
        while (pending_beats.size() != 0 || s_valid || expected_terms.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid    <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end else begin
            if (s_valid && s_ready) predict_terms(s_data);
            if (!s_valid || s_ready) begin
                if (burst_left == 0 && gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (pending_beats.size() != 0) begin
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 16);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                    burst_left--;
                    s_valid <= 1'b1;
                    s_data  <= pending_beats.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            rx_tick <= rx_tick + 1'b1;
            if (rx_left == 0) begin
                rx_mode = rx_mode_t'($urandom_range(0, 3));
                rx_left = $urandom_range(16, 96);
            end else begin
                rx_left--;
            end
            case (rx_mode)
                RX_FREE:   m_ready <= 1'b1;
                RX_COIN:   m_ready <= 1'($urandom_range(0, 1));
                RX_SPARSE: m_ready <= ($urandom_range(0, 3) == 0);
                default:   m_ready <= rx_tick[2];
            endcase
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_terms.size() == 0) begin
                report_mismatch($sformatf("unexpected result beat, coefficient %0d exponent %0d",
                                          m_data.coefficient_out, m_data.exponent_out));
            end else begin
                want = expected_terms.pop_front();
                if (m_data.coefficient_out !== want.coefficient_out)
                    report_mismatch($sformatf("coefficient_out %0d, expected %0d",
                                              m_data.coefficient_out, want.coefficient_out));
                if (m_data.exponent_out !== want.exponent_out)
                    report_mismatch($sformatf("exponent_out %0d, expected %0d",
                                              m_data.exponent_out, want.exponent_out));
                if (m_data.last_term !== want.last_term)
                    report_mismatch($sformatf("last_term %0b, expected %0b",
                                              m_data.last_term, want.last_term));
            end
        end
    end

    initial begin
        in_item_t         beat;
        int               real_left;
        logic [DEG_W-1:0] da;
        logic [DEG_W-1:0] db;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        set_degrees(DEG_TOP, DEG_TOP);
        for (int k = 0; k < MAX_TERMS; k++) begin
            pending_beats.push_back(make_beat(OP_LOAD_A, k, edge_coef(k)));
            pending_beats.push_back(make_beat(OP_LOAD_B, k, edge_coef(MAX_TERMS - 1 - k)));
        end
        pending_beats.push_back(make_beat(OP_ADD, MAX_TERMS - 1, 16'shFFFF));
        pending_beats.push_back(make_beat(OP_SUB, 0, 16'sh7FFF));
        pending_beats.push_back(make_beat(OP_MUL, 5, 16'sh8000));
        for (int op = int'(OP_MUL) + 1; op < (1 << OPC_W); op++)
            pending_beats.push_back(make_beat(OPC_W'(op), op, edge_coef(op)));
        pending_beats.push_back(make_beat(OP_LOAD_A, 3, 16'sh8000));
        pending_beats.push_back(make_beat(OP_LOAD_B, 4, 16'sh8000));
        pending_beats.push_back(make_beat(OP_MUL, 0, 16'sh0000));
        wait_idle();
        for (int p = 0; p < 8; p++) begin
            case (p)
                0: begin da = '0;      db = '0;      end
                1: begin da = DEG_TOP; db = '0;      end
                2: begin da = '0;      db = DEG_TOP; end
                3: begin da = DEG_TOP; db = DEG_TOP; end
                default: begin
                    da = DEG_W'($urandom_range(0, MAX_TERMS - 1));
                    db = DEG_W'($urandom_range(0, MAX_TERMS - 1));
                end
            endcase
            set_degrees(da, db);
            for (int half = 0; half < 2; half++) begin
                real_left = 13;
                while (real_left > 0) begin
                    beat = random_beat();
                    pending_beats.push_back(beat);
                    if (beat.opcode <= OP_MUL) real_left--;
                end
                wait_idle();
            end
        end
        repeat (20) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("dense_polynomial_alu verification clean");
        end else begin
            $display("dense_polynomial_alu verification failed");
        end
        $finish;
    end

    initial begin
        #(10_000_000);
        $display("ERROR: run timed out");
        $display("dense_polynomial_alu verification failed");
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/dpa_pkg.sv
hw/rtl/dpa_coef_store.sv
hw/rtl/dpa_sequencer.sv
hw/rtl/dpa_arith_unit.sv
hw/rtl/dense_polynomial_alu.sv
tb/sv/dense_polynomial_alu_tb.sv
